FILE: rtl/core/rcq_pkg.sv
// ----------------------------------------------------------------------------
// rcq_pkg
// Shared types, opcodes, status codes and controller interface structs for
// the range classified queues block.
// ----------------------------------------------------------------------------
package rcq_pkg;

  localparam int NUM_CAT     = 4;
  localparam int CAT_W       = 2;
  localparam int DATA_W      = 32;
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = $clog2(MAX_RESULTS);

  // opcodes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_TAKE   = 2'd1;
  localparam logic [1:0] OP_LIST   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_DELIVERED = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_FIRST_LIMIT  = 2'd0;
  localparam logic [1:0] REG_SECOND_LIMIT = 2'd1;
  localparam logic [1:0] REG_THIRD_LIMIT  = 2'd2;

  // reset limits
  localparam logic signed [DATA_W-1:0] FIRST_LIMIT_RST  = 32'sd10;
  localparam logic signed [DATA_W-1:0] SECOND_LIMIT_RST = 32'sd19;
  localparam logic signed [DATA_W-1:0] THIRD_LIMIT_RST  = 32'sd29;

  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [DATA_W-1:0] value;
    logic [CAT_W-1:0]         category_select;
  } in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [CAT_W-1:0]         category;
    logic signed [DATA_W-1:0] item_value;
    logic                     last;
  } out_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic insert;
    logic take;
    logic take_emit;
    logic list_start;
    logic list_read;
    logic list_emit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [1:0] opcode;
    logic       out_free;
    logic       take_empty;
    logic       any_held;
    logic       list_last;
  } sts_t;

endpackage

FILE: rtl/core/rcq_ram.sv
// ----------------------------------------------------------------------------
// rcq_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rcq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, hold between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/rcq_datapath.sv
// ----------------------------------------------------------------------------
// rcq_datapath
// Limit registers, classifier, queue positions, entry store, list cursor and
// result register.
// ----------------------------------------------------------------------------
module rcq_datapath #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [rcq_pkg::DATA_W-1:0] cfg_data,
  input  rcq_pkg::in_t               in_data,
  input  rcq_pkg::cmd_t              cmd,
  output rcq_pkg::sts_t              sts,
  output logic                       out_valid,
  input  logic                       out_stall,
  output rcq_pkg::out_t              out_data
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int PW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = IW + rcq_pkg::CAT_W;
  localparam int NC = rcq_pkg::NUM_CAT;
  localparam logic [PW-1:0] DEPTH_P = PW'(QUEUE_DEPTH);

  logic signed [rcq_pkg::DATA_W-1:0] first_limit;
  logic signed [rcq_pkg::DATA_W-1:0] second_limit;
  logic signed [rcq_pkg::DATA_W-1:0] third_limit;

  rcq_pkg::in_t         in_reg;
  logic [PW-1:0]        front [NC];
  logic [PW-1:0]        fill  [NC];
  logic [rcq_pkg::CAT_W-1:0] list_cat;
  logic [PW-1:0]        list_pos;
  logic                 list_new;
  logic [rcq_pkg::CNT_W-1:0] list_cnt;

  logic [rcq_pkg::CAT_W-1:0] class_cat;
  logic [rcq_pkg::CAT_W-1:0] cat_idx;
  logic [PW-1:0]        cur_front;
  logic [PW-1:0]        cur_fill;
  logic [PW-1:0]        rd_pos;
  logic [PW-1:0]        pos_inc;
  logic [NC-1:0]        nonempty;
  logic                 later_any;
  logic [rcq_pkg::CAT_W-1:0] first_cat;
  logic [rcq_pkg::CAT_W-1:0] next_cat;
  logic                 full;
  logic                 out_free;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [rcq_pkg::DATA_W-1:0] ram_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_limit  <= rcq_pkg::FIRST_LIMIT_RST;
      second_limit <= rcq_pkg::SECOND_LIMIT_RST;
      third_limit  <= rcq_pkg::THIRD_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rcq_pkg::REG_FIRST_LIMIT:  first_limit  <= cfg_data;
        rcq_pkg::REG_SECOND_LIMIT: second_limit <= cfg_data;
        rcq_pkg::REG_THIRD_LIMIT:  third_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold the accepted input
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_reg <= in_data;
    end
  end

  // classify the held value
  always_comb begin
    priority if (in_reg.value < first_limit) begin
      class_cat = 2'd0;
    end else if (in_reg.value <= second_limit) begin
      class_cat = 2'd1;
    end else if (in_reg.value <= third_limit) begin
      class_cat = 2'd2;
    end else begin
      class_cat = 2'd3;
    end
  end

  // pick the one category the current command works on
  always_comb begin
    priority if (cmd.insert) begin
      cat_idx = class_cat;
    end else if (cmd.take) begin
      cat_idx = in_reg.category_select;
    end else begin
      cat_idx = list_cat;
    end
  end

  assign cur_front = front[cat_idx];
  assign cur_fill  = fill[cat_idx];
  assign full      = (cur_fill >= DEPTH_P);

  // occupancy of every queue and the list walk's next category
  always_comb begin
    for (int c = 0; c < NC; c++) begin
      nonempty[c] = (fill[c] > front[c]);
    end
    first_cat = '0;
    for (int c = NC - 1; c >= 0; c--) begin
      if (nonempty[c]) begin
        first_cat = rcq_pkg::CAT_W'(c);
      end
    end
    later_any = 1'b0;
    next_cat  = '0;
    for (int c = NC - 1; c >= 0; c--) begin
      if (nonempty[c] && (rcq_pkg::CAT_W'(c) > list_cat)) begin
        later_any = 1'b1;
        next_cat  = rcq_pkg::CAT_W'(c);
      end
    end
  end

  assign rd_pos  = cmd.take ? cur_front : (list_new ? cur_front : list_pos);
  assign pos_inc = list_pos + PW'(1);

  // status back to the controller, taken from registers and the out_stall input
  assign out_free       = !out_valid || !out_stall;
  assign sts.opcode     = in_reg.opcode;
  assign sts.out_free   = out_free;
  assign sts.take_empty = (front[in_reg.category_select] >= fill[in_reg.category_select]);
  assign sts.any_held   = |nonempty;
  assign sts.list_last  = (list_cnt == rcq_pkg::CNT_W'(rcq_pkg::MAX_RESULTS - 1)) ||
                          ((pos_inc >= fill[list_cat]) && !later_any);

  // queue positions
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NC; c++) begin
        front[c] <= '0;
        fill[c]  <= '0;
      end
    end else if (cmd.insert && !full) begin
      fill[cat_idx] <= cur_fill + PW'(1);
    end else if (cmd.take && !sts.take_empty) begin
      if (cur_front + PW'(1) >= cur_fill) begin
        front[cat_idx] <= '0;
        fill[cat_idx]  <= '0;
      end else begin
        front[cat_idx] <= cur_front + PW'(1);
      end
    end
  end

  // list cursor
  always_ff @(posedge clk) begin
    if (cmd.list_start) begin
      list_cat <= first_cat;
      list_new <= 1'b1;
      list_cnt <= '0;
    end else if (cmd.list_read) begin
      list_pos <= rd_pos;
      list_new <= 1'b0;
    end else if (cmd.list_emit) begin
      list_cnt <= list_cnt + rcq_pkg::CNT_W'(1);
      if (pos_inc < cur_fill) begin
        list_pos <= pos_inc;
      end else begin
        list_cat <= next_cat;
        list_new <= 1'b1;
      end
    end
  end

  // entry store access
  assign ram_we    = cmd.insert && !full;
  assign ram_waddr = {cat_idx, cur_fill[IW-1:0]};
  assign ram_re    = (cmd.take && !sts.take_empty) || cmd.list_read;
  assign ram_raddr = {cat_idx, rd_pos[IW-1:0]};

  rcq_ram #(
    .WIDTH (rcq_pkg::DATA_W),
    .DEPTH (rcq_pkg::NUM_CAT << IW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_reg.value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.insert || (cmd.take && sts.take_empty) ||
                 (cmd.list_start && !sts.any_held) || cmd.take_emit || cmd.list_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    priority if (cmd.insert) begin
      out_data.status     <= full ? rcq_pkg::ST_FULL : rcq_pkg::ST_INSERTED;
      out_data.category   <= class_cat;
      out_data.item_value <= '0;
      out_data.last       <= 1'b1;
    end else if (cmd.take && sts.take_empty) begin
      out_data.status     <= rcq_pkg::ST_EMPTY;
      out_data.category   <= in_reg.category_select;
      out_data.item_value <= '0;
      out_data.last       <= 1'b1;
    end else if (cmd.list_start && !sts.any_held) begin
      out_data.status     <= rcq_pkg::ST_EMPTY;
      out_data.category   <= '0;
      out_data.item_value <= '0;
      out_data.last       <= 1'b1;
    end else if (cmd.take_emit) begin
      out_data.status     <= rcq_pkg::ST_DELIVERED;
      out_data.category   <= in_reg.category_select;
      out_data.item_value <= ram_rdata;
      out_data.last       <= 1'b1;
    end else if (cmd.list_emit) begin
      out_data.status     <= rcq_pkg::ST_DELIVERED;
      out_data.category   <= list_cat;
      out_data.item_value <= ram_rdata;
      out_data.last       <= sts.list_last;
    end else begin
      out_data <= out_data;
    end
  end

endmodule

FILE: rtl/core/rcq_ctrl.sv
// ----------------------------------------------------------------------------
// rcq_ctrl
// Controller: sequences insert, take and list operations over the datapath.
// ----------------------------------------------------------------------------
module rcq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  rcq_pkg::sts_t sts,
  output rcq_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EXEC     = 3'd1;
  localparam logic [2:0] S_TAKE_OUT = 3'd2;
  localparam logic [2:0] S_LIST_RD  = 3'd3;
  localparam logic [2:0] S_LIST_OUT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          unique case (sts.opcode)
            rcq_pkg::OP_INSERT: begin
              cmd.insert = 1'b1;
              state_next = S_IDLE;
            end
            rcq_pkg::OP_TAKE: begin
              cmd.take   = 1'b1;
              state_next = sts.take_empty ? S_IDLE : S_TAKE_OUT;
            end
            rcq_pkg::OP_LIST: begin
              cmd.list_start = 1'b1;
              state_next     = sts.any_held ? S_LIST_RD : S_IDLE;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_TAKE_OUT: begin
        if (sts.out_free) begin
          cmd.take_emit = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_LIST_RD: begin
        cmd.list_read = 1'b1;
        state_next    = S_LIST_OUT;
      end
      S_LIST_OUT: begin
        if (sts.out_free) begin
          cmd.list_emit = 1'b1;
          state_next    = sts.list_last ? S_IDLE : S_LIST_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/core/range_classified_queues_core.sv
// ----------------------------------------------------------------------------
// range_classified_queues_core
// Four linear array queues fed by a three-limit range classifier.
// Insert: captured, then classified and answered; next item once back to idle.
// Take: an empty answer comes straight from the exec state; otherwise the store
// is read first. List: one store read and then one result for each held entry.
// Synchronous reset clears positions and loads limits 10, 19, 29; the entry
// store is not cleared, so the block is ready right after reset.
// ----------------------------------------------------------------------------
module range_classified_queues_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  rcq_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output rcq_pkg::out_t              out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [rcq_pkg::DATA_W-1:0] cfg_data
);

  rcq_pkg::cmd_t cmd;
  rcq_pkg::sts_t sts;

  // registers take a write on any cycle
  assign cfg_ready = 1'b1;

  rcq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rcq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for range_classified_queues_core. A behavioral copy of
// the four linear queues and the limit classifier predicts every result beat;
// a monitor compares each beat leaving the block with the oldest prediction.
// Directed items cover empty answers, limit boundaries and the linear full
// rule, then shaped random traffic runs under three limit settings and three
// back-pressure mixes.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int QDEPTH      = 16;
  localparam int SETTLE_CYC  = 8;
  localparam int QUIET_LIMIT = 5000;

  // opcode 3 has no function; the block must ignore it
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic          in_valid  = 1'b0;
  logic          in_stall;
  rcq_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  rcq_pkg::out_t out_data;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [1:0]    cfg_index = '0;
  logic [31:0]   cfg_data  = '0;

  // behavioral copy of the queues and limits
  logic signed [31:0] lim_first  = rcq_pkg::FIRST_LIMIT_RST;
  logic signed [31:0] lim_second = rcq_pkg::SECOND_LIMIT_RST;
  logic signed [31:0] lim_third  = rcq_pkg::THIRD_LIMIT_RST;
  logic signed [31:0] held_entries [rcq_pkg::NUM_CAT][QDEPTH];
  int                 head_pos [rcq_pkg::NUM_CAT] = '{default: 0};
  int                 tail_pos [rcq_pkg::NUM_CAT] = '{default: 0};
  rcq_pkg::out_t      pending_results [$];

  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            error_count   = 0;
  int            quiet_cycles  = 0;
  rcq_pkg::out_t want_result;

  always #10 clk = ~clk;

  range_classified_queues_core #(
    .QUEUE_DEPTH(QDEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic logic [1:0] classify_value(input logic signed [31:0] v);
    if (v < lim_first) return 2'd0;
    if (v <= lim_second) return 2'd1;
    if (v <= lim_third) return 2'd2;
    return 2'd3;
  endfunction

  // Advance the queue copy by one accepted beat and queue its result beats
  function automatic void apply_queue_op(input rcq_pkg::in_t it);
    rcq_pkg::out_t r;
    logic [1:0]    c;
    int            held;
    int            n;
    int            k;
    int            p;
    r = '0;
    case (it.opcode)
      rcq_pkg::OP_INSERT: begin
        c = classify_value(it.value);
        r.category = c;
        r.last     = 1'b1;
        if (tail_pos[c] >= QDEPTH) begin
          r.status = rcq_pkg::ST_FULL;
        end else begin
          held_entries[c][tail_pos[c]] = it.value;
          tail_pos[c]++;
          r.status = rcq_pkg::ST_INSERTED;
        end
        pending_results.push_back(r);
      end
      rcq_pkg::OP_TAKE: begin
        c = it.category_select;
        r.category = c;
        r.last     = 1'b1;
        if (head_pos[c] >= tail_pos[c]) begin
          r.status = rcq_pkg::ST_EMPTY;
        end else begin
          r.status     = rcq_pkg::ST_DELIVERED;
          r.item_value = held_entries[c][head_pos[c]];
          head_pos[c]++;
          // a take that empties the queue rewinds both positions
          if (head_pos[c] >= tail_pos[c]) begin
            head_pos[c] = 0;
            tail_pos[c] = 0;
          end
        end
        pending_results.push_back(r);
      end
      rcq_pkg::OP_LIST: begin
        held = 0;
        for (k = 0; k < rcq_pkg::NUM_CAT; k++) held += tail_pos[k] - head_pos[k];
        if (held > rcq_pkg::MAX_RESULTS) held = rcq_pkg::MAX_RESULTS;
        if (held == 0) begin
          r.status = rcq_pkg::ST_EMPTY;
          r.last   = 1'b1;
          pending_results.push_back(r);
        end else begin
          n = 0;
          for (k = 0; k < rcq_pkg::NUM_CAT; k++) begin
            for (p = head_pos[k]; p < tail_pos[k] && n < held; p++) begin
              r.status     = rcq_pkg::ST_DELIVERED;
              r.category   = 2'(k);
              r.item_value = held_entries[k][p];
              r.last       = (n == held - 1);
              pending_results.push_back(r);
              n++;
            end
          end
        end
      end
      default: begin
        // ignored opcode: no beats, no state change
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic rcq_pkg::in_t build_item(input logic [1:0] op,
                                              input logic signed [31:0] v,
                                              input logic [1:0] sel);
    rcq_pkg::in_t it;
    it.opcode          = op;
    it.value           = v;
    it.category_select = sel;
    return it;
  endfunction

  // Favor values near the limits, with full-range and extreme values mixed in
  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] base;
    int                 offs;
    case ($urandom_range(5))
      0, 1: return $urandom;
      2: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: begin
        case ($urandom_range(2))
          0: base = lim_first;
          1: base = lim_second;
          default: base = lim_third;
        endcase
        offs = int'($urandom_range(6)) - 3;
        return base + offs;
      end
    endcase
  endfunction

  // Search for a value that lands in the wanted category; give up quietly
  function automatic logic signed [31:0] value_for_category(input logic [1:0] c);
    logic signed [31:0] v;
    int                 tries;
    v = pick_value();
    for (tries = 0; tries < 32 && classify_value(v) != c; tries++) v = pick_value();
    return v;
  endfunction

  // Send one input beat; valid stays high afterwards unless the next call idles
  task automatic send_item(input rcq_pkg::in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    apply_queue_op(it);
  endtask

  // Drop valid and let every predicted beat drain, then allow the block to settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // One register beat; cfg_valid is left high for the caller
  task automatic write_limit(input logic [1:0] idx, input logic signed [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      rcq_pkg::REG_FIRST_LIMIT:  lim_first  = v;
      rcq_pkg::REG_SECOND_LIMIT: lim_second = v;
      rcq_pkg::REG_THIRD_LIMIT:  lim_third  = v;
      default: ;
    endcase
  endtask

  task automatic load_limits(input logic signed [31:0] first,
                             input logic signed [31:0] second,
                             input logic signed [31:0] third);
    write_limit(rcq_pkg::REG_FIRST_LIMIT, first);
    write_limit(rcq_pkg::REG_SECOND_LIMIT, second);
    write_limit(rcq_pkg::REG_THIRD_LIMIT, third);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Empty answers from list and take, and the ignored opcode
  task automatic test_empty_responses();
    send_item(build_item(rcq_pkg::OP_LIST, $urandom, 2'($urandom_range(3))));
    send_item(build_item(rcq_pkg::OP_TAKE, $urandom, 2'd2));
    send_item(build_item(OP_UNUSED, $urandom, 2'($urandom_range(3))));
  endtask

  // Values at each reset limit and just above the second and third, plus the value extremes
  task automatic test_limit_bounds();
    send_item(build_item(rcq_pkg::OP_INSERT, 32'sh8000_0000, 2'd3));
    send_item(build_item(rcq_pkg::OP_INSERT, 32'sd10, 2'd0));
    send_item(build_item(rcq_pkg::OP_INSERT, 32'sd19, 2'd2));
    send_item(build_item(rcq_pkg::OP_INSERT, 32'sd20, 2'd1));
    send_item(build_item(rcq_pkg::OP_INSERT, 32'sd29, 2'd0));
    send_item(build_item(rcq_pkg::OP_INSERT, 32'sd30, 2'd1));
    send_item(build_item(rcq_pkg::OP_INSERT, 32'sh7fff_ffff, 2'd2));
    send_item(build_item(rcq_pkg::OP_LIST, $urandom, 2'($urandom_range(3))));
    // take the only entry of category 0, which rewinds its positions
    send_item(build_item(rcq_pkg::OP_TAKE, $urandom, 2'd0));
  endtask

  // Fill category 3 until an insert is refused, take one entry, insert again; still full
  task automatic test_linear_full();
    int k;
    for (k = 0; k < QDEPTH - 2; k++) begin
      send_item(build_item(rcq_pkg::OP_INSERT, 32'sd31 + k, 2'd0));
    end
    send_item(build_item(rcq_pkg::OP_INSERT, 32'sd1000, 2'd1));
    send_item(build_item(rcq_pkg::OP_TAKE, $urandom, 2'd3));
    send_item(build_item(rcq_pkg::OP_INSERT, 32'sh7fff_fffe, 2'd2));
  endtask

  // Bursts that fill and drain single queues, lists, and scattered noise
  task automatic test_mixed_traffic(input int send_pct, input int recv_pct,
                                    input logic signed [31:0] first,
                                    input logic signed [31:0] second,
                                    input logic signed [31:0] third,
                                    input int target);
    int           sent;
    int           burst;
    int           k;
    logic [1:0]   c;
    rcq_pkg::in_t it;
    wait_idle();
    load_limits(first, second, third);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < target) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          c     = 2'($urandom_range(3));
          burst = $urandom_range(4, 20);
          for (k = 0; k < burst; k++) begin
            send_item(build_item(rcq_pkg::OP_INSERT, value_for_category(c),
                                 2'($urandom_range(3))));
            sent++;
          end
        end
        4, 5, 6: begin
          c     = 2'($urandom_range(3));
          burst = $urandom_range(1, 18);
          for (k = 0; k < burst; k++) begin
            send_item(build_item(rcq_pkg::OP_TAKE, $urandom, c));
            sent++;
          end
        end
        7, 8: begin
          for (k = 0; k < 6; k++) begin
            it = build_item(2'($urandom_range(3)), pick_value(), 2'($urandom_range(3)));
            send_item(it);
            if (it.opcode != OP_UNUSED) sent++;
          end
        end
        default: begin
          send_item(build_item(rcq_pkg::OP_LIST, $urandom, 2'($urandom_range(3))));
          sent++;
        end
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Result monitor and receiver back-pressure
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result beat: expected none, got status=%0d cat=%0d",
                   $time, out_data.status, out_data.category,
                   " value=%0d last=%0d", out_data.item_value, out_data.last);
        end else begin
          want_result = pending_results.pop_front();
          if (out_data.status !== want_result.status ||
              out_data.category !== want_result.category ||
              out_data.item_value !== want_result.item_value ||
              out_data.last !== want_result.last) begin
            error_count++;
            $display("%0t: result mismatch: expected status=%0d cat=%0d value=%0d last=%0d,",
                     $time, want_result.status, want_result.category,
                     want_result.item_value, want_result.last,
                     " got status=%0d cat=%0d value=%0d last=%0d", out_data.status,
                     out_data.category, out_data.item_value, out_data.last);
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: end the run when no channel moves a beat for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_empty_responses();
    test_limit_bounds();
    test_linear_full();
    test_mixed_traffic(16, 58, -32'sd50, 32'sd0, 32'sd50, 100);
    test_mixed_traffic(58, 16, 32'sh8000_0000, 32'sd0, 32'sh7fff_ffff, 100);
    test_mixed_traffic(0, 0, 32'sh7fff_ffff, 32'sh8000_0000, -32'sd1, 100);
    wait_idle();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
